### sv/mlfc_pkg.sv
// ----------------------------------------------------------------------------
// Memory LCD frame controller package
// Shared constants, register codes and the configuration bundle type.
// ----------------------------------------------------------------------------
package mlfc_pkg;

    localparam int PANEL_WIDTH_DEF  = 230;
    localparam int PANEL_HEIGHT_DEF = 303;
    localparam int ROW_STRIDE_DEF   = 240;

    localparam logic [2:0] MODE_DRAW      = 3'd0;
    localparam logic [2:0] MODE_READ      = 3'd1;
    localparam logic [2:0] MODE_CLR_STORE = 3'd2;
    localparam logic [2:0] MODE_CLR_DISP  = 3'd3;
    localparam logic [2:0] MODE_REFRESH   = 3'd4;
    localparam logic [2:0] MODE_END_FRAME = 3'd5;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [1:0] REG_ROTATION  = 2'd0;
    localparam logic [1:0] REG_WRITE_CMD = 2'd1;
    localparam logic [1:0] REG_VCOM      = 2'd2;
    localparam logic [1:0] REG_CLEAR_CMD = 2'd3;

    localparam logic [1:0] ROTATION_RST  = 2'd0;
    localparam logic [7:0] WRITE_CMD_RST = 8'h01;
    localparam logic [7:0] VCOM_RST      = 8'h02;
    localparam logic [7:0] CLEAR_CMD_RST = 8'h04;

    localparam logic [7:0] LINE_ODD_BIT = 8'h80;
    localparam logic [7:0] BYTE_FILL    = 8'hFF;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;

    typedef struct packed {
        logic [1:0] rotation;
        logic [7:0] write_cmd_mask;
        logic [7:0] vcom_mask;
        logic [7:0] clear_cmd_mask;
    } t_cfg;

endpackage

### sv/mlfc_regs.sv
// ----------------------------------------------------------------------------
// Memory LCD frame controller configuration registers
// Register file behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module mlfc_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output mlfc_pkg::t_cfg    o_cfg
);

    mlfc_pkg::t_cfg r_cfg;
    logic           wr_en;
    logic [1:0]     reg_ix;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign reg_ix = paddr[3:2];
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation       <= mlfc_pkg::ROTATION_RST;
            r_cfg.write_cmd_mask <= mlfc_pkg::WRITE_CMD_RST;
            r_cfg.vcom_mask      <= mlfc_pkg::VCOM_RST;
            r_cfg.clear_cmd_mask <= mlfc_pkg::CLEAR_CMD_RST;
        end else if (wr_en) begin
            case (reg_ix)
                mlfc_pkg::REG_ROTATION:  r_cfg.rotation       <= pwdata[1:0];
                mlfc_pkg::REG_WRITE_CMD: r_cfg.write_cmd_mask <= pwdata[7:0];
                mlfc_pkg::REG_VCOM:      r_cfg.vcom_mask      <= pwdata[7:0];
                mlfc_pkg::REG_CLEAR_CMD: r_cfg.clear_cmd_mask <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_ix)
            mlfc_pkg::REG_ROTATION:  prdata = {30'd0, r_cfg.rotation};
            mlfc_pkg::REG_WRITE_CMD: prdata = {24'd0, r_cfg.write_cmd_mask};
            mlfc_pkg::REG_VCOM:      prdata = {24'd0, r_cfg.vcom_mask};
            mlfc_pkg::REG_CLEAR_CMD: prdata = {24'd0, r_cfg.clear_cmd_mask};
            default:                 prdata = 32'd0;
        endcase
    end

endmodule

### sv/mlfc_store.sv
// ----------------------------------------------------------------------------
// Memory LCD frame controller frame store
// One-bit-per-pixel frame memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module mlfc_store #(
    parameter int DEPTH  = 9090,
    parameter int ADDR_W = 14
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [7:0]        i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [7:0]        o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

endmodule

### sv/mlfc_locate.sv
// ----------------------------------------------------------------------------
// Memory LCD frame controller pixel locator
// Maps rotated coordinates to a store byte and bit, registered, with bounds check.
// ----------------------------------------------------------------------------
module mlfc_locate #(
    parameter int PANEL_WIDTH  = mlfc_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = mlfc_pkg::PANEL_HEIGHT_DEF,
    parameter int ROW_STRIDE   = mlfc_pkg::ROW_STRIDE_DEF,
    parameter int ADDR_W       = 14
) (
    input  logic              i_clk,
    input  logic [1:0]        i_rotation,
    input  logic [10:0]       i_x,
    input  logic [10:0]       i_y,
    output logic              o_hit,
    output logic [ADDR_W-1:0] o_addr,
    output logic [2:0]        o_bit
);

    localparam int STORE_BYTES = (ROW_STRIDE * PANEL_HEIGHT) / 8;
    localparam int LIN_W       = $clog2(PANEL_HEIGHT * ROW_STRIDE + PANEL_WIDTH + 1);
    localparam logic [10:0] W11 = 11'(PANEL_WIDTH);
    localparam logic [10:0] H11 = 11'(PANEL_HEIGHT);

    logic [10:0]      rot_w;
    logic [10:0]      rot_h;
    logic             in_range;
    logic [10:0]      px;
    logic [10:0]      py;
    logic [LIN_W-1:0] lin;
    logic [LIN_W-4:0] byte_ix;
    logic             hit;

    logic              r_hit;
    logic [ADDR_W-1:0] r_addr;
    logic [2:0]        r_bit;

    always_comb begin
        rot_w    = i_rotation[0] ? H11 : W11;
        rot_h    = i_rotation[0] ? W11 : H11;
        in_range = !i_x[10] && !i_y[10] && (i_x < rot_w) && (i_y < rot_h);
        case (i_rotation)
            mlfc_pkg::ROT_90: begin
                px = W11 - 11'd1 - i_y;
                py = i_x;
            end
            mlfc_pkg::ROT_180: begin
                px = W11 - 11'd1 - i_x;
                py = H11 - 11'd1 - i_y;
            end
            mlfc_pkg::ROT_270: begin
                px = i_y;
                py = H11 - 11'd1 - i_x;
            end
            default: begin
                px = i_x;
                py = i_y;
            end
        endcase
        lin     = LIN_W'(py) * LIN_W'(ROW_STRIDE) + LIN_W'(px);
        byte_ix = lin[LIN_W-1:3];
        hit     = in_range && (byte_ix < (LIN_W-3)'(STORE_BYTES));
    end

    always_ff @(posedge i_clk) begin
        r_hit  <= hit;
        r_addr <= ADDR_W'(byte_ix);
        r_bit  <= px[2:0];
    end

    assign o_hit  = r_hit;
    assign o_addr = r_addr;
    assign o_bit  = r_bit;

endmodule

### sv/memory_lcd_frame_controller.sv
// ----------------------------------------------------------------------------
// Memory LCD frame controller, top level
// Draw and read each pass ST_LOC, ST_RD and ST_MOD; a read emits its result from ST_MOD. One item at a time.
// Refresh line: header, line number, then each row byte as a store read then emit, then a tail byte.
// Clears walk the store one byte a cycle, ROW_STRIDE*PANEL_HEIGHT/8 bytes (9090).
// After reset the same clearing pass runs before the first item is accepted.
// ----------------------------------------------------------------------------
module memory_lcd_frame_controller #(
    parameter int PANEL_WIDTH  = mlfc_pkg::PANEL_WIDTH_DEF,
    parameter int PANEL_HEIGHT = mlfc_pkg::PANEL_HEIGHT_DEF,
    parameter int ROW_STRIDE   = mlfc_pkg::ROW_STRIDE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input item stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: x_pos[10:0], y_pos[21:11], color[22], zero pad[23].
    input  logic [23:0] s_axis_tdata,
    // tuser: mode[2:0].
    input  logic [2:0]  s_axis_tuser,
    // Result item stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: data_byte[7:0], pixel_value[8], select_end[9], zero pad[15:10].
    output logic [15:0] m_axis_tdata,
    // tuser: kind[0].
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int STORE_BYTES = (ROW_STRIDE * PANEL_HEIGHT) / 8;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int PER         = ROW_STRIDE / 8;
    localparam int CNT_W       = (PER > 1) ? $clog2(PER) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BYTES - 1);
    localparam logic [10:0]       H11       = 11'(PANEL_HEIGHT);

    typedef enum logic [3:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_LOC,
        ST_RD,
        ST_MOD,
        ST_HDR,
        ST_NUM,
        ST_ROW_RD,
        ST_ROW_WT,
        ST_TAIL,
        ST_CMD0,
        ST_CMD1
    } t_state;

    mlfc_pkg::t_cfg cfg;

    t_state            r_state;
    logic [2:0]        r_mode;
    logic [10:0]       r_x;
    logic [10:0]       r_y;
    logic              r_color;
    logic              r_clr_emit;
    logic              r_vcom;
    logic [ADDR_W-1:0] r_addr;
    logic [CNT_W-1:0]  r_cnt;
    logic [10:0]       r_line;

    logic              r_o_valid;
    logic              r_o_kind;
    logic [7:0]        r_o_data;
    logic              r_o_pix;
    logic              r_o_sel;
    logic              r_o_last;

    logic              loc_hit;
    logic [ADDR_W-1:0] loc_addr;
    logic [2:0]        loc_bit;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [7:0]        mem_rdata;

    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [7:0]        vcom_bits;
    logic [10:0]       in_x;
    logic [10:0]       in_y;
    logic              row_ok;
    logic [ADDR_W-1:0] n_base;
    logic [7:0]        bit_mask;

    assign in_x      = s_axis_tdata[10:0];
    assign in_y      = s_axis_tdata[21:11];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_o_valid || m_axis_tready;
    assign out_load  = out_free
                       && ((r_state inside {ST_HDR, ST_NUM, ST_ROW_WT, ST_TAIL, ST_CMD0,
                                            ST_CMD1})
                           || ((r_state == ST_MOD) && (r_mode != mlfc_pkg::MODE_DRAW)));
    assign vcom_bits = r_vcom ? cfg.vcom_mask : mlfc_pkg::BYTE_ZERO;
    assign row_ok    = !in_y[10] && (in_y < H11);
    assign n_base    = ADDR_W'(in_y[9:0]) * ADDR_W'(PER);
    assign bit_mask  = 8'd1 << loc_bit;

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {6'd0, r_o_sel, r_o_pix, r_o_data};
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_last;

    mlfc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mlfc_locate #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT),
        .ROW_STRIDE   (ROW_STRIDE),
        .ADDR_W       (ADDR_W)
    ) u_locate (
        .i_clk      (i_clk),
        .i_rotation (cfg.rotation),
        .i_x        (r_x),
        .i_y        (r_y),
        .o_hit      (loc_hit),
        .o_addr     (loc_addr),
        .o_bit      (loc_bit)
    );

    mlfc_store #(
        .DEPTH  (STORE_BYTES),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // The read of a draw finishes before its write, and the next item is
    // taken only after the write, so store accesses never overlap.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_addr;
        mem_wdata = mlfc_pkg::BYTE_FILL;
        mem_re    = 1'b0;
        mem_raddr = r_addr;
        case (r_state)
            ST_SWEEP: begin
                mem_we = 1'b1;
            end
            ST_RD: begin
                mem_re    = loc_hit;
                mem_raddr = loc_addr;
            end
            ST_MOD: begin
                mem_we    = (r_mode == mlfc_pkg::MODE_DRAW) && loc_hit;
                mem_waddr = loc_addr;
                mem_wdata = r_color ? (mem_rdata | bit_mask) : (mem_rdata & ~bit_mask);
            end
            ST_ROW_RD: begin
                mem_re = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_SWEEP;
            r_addr     <= '0;
            r_clr_emit <= 1'b0;
            r_vcom     <= 1'b1;
            r_o_valid  <= 1'b0;
        end else begin
            if (m_axis_tready && !out_load) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                ST_SWEEP: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == LAST_ADDR) begin
                        r_state <= r_clr_emit ? ST_CMD0 : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_mode  <= s_axis_tuser;
                        r_x     <= in_x;
                        r_y     <= in_y;
                        r_color <= s_axis_tdata[22];
                        case (s_axis_tuser)
                            mlfc_pkg::MODE_DRAW, mlfc_pkg::MODE_READ: begin
                                r_state <= ST_LOC;
                            end
                            mlfc_pkg::MODE_CLR_STORE: begin
                                r_addr     <= '0;
                                r_clr_emit <= 1'b0;
                                r_state    <= ST_SWEEP;
                            end
                            mlfc_pkg::MODE_CLR_DISP: begin
                                r_addr     <= '0;
                                r_clr_emit <= 1'b1;
                                r_state    <= ST_SWEEP;
                            end
                            mlfc_pkg::MODE_REFRESH: begin
                                r_addr  <= n_base;
                                r_cnt   <= CNT_W'(PER - 1);
                                r_line  <= in_y + 11'd1;
                                r_state <= row_ok ? ST_HDR : ST_IDLE;
                            end
                            mlfc_pkg::MODE_END_FRAME: begin
                                r_state <= ST_CMD0;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_LOC: begin
                    r_state <= ST_RD;
                end
                ST_RD: begin
                    r_state <= ST_MOD;
                end
                ST_MOD: begin
                    if (r_mode == mlfc_pkg::MODE_DRAW) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= 1'b0;
                        r_o_data  <= mlfc_pkg::BYTE_ZERO;
                        r_o_pix   <= loc_hit && mem_rdata[loc_bit];
                        r_o_sel   <= 1'b0;
                        r_o_last  <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                ST_HDR: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= 1'b1;
                        r_o_data  <= (r_line[0] ? mlfc_pkg::LINE_ODD_BIT : mlfc_pkg::BYTE_ZERO)
                                     | vcom_bits | cfg.write_cmd_mask;
                        r_o_pix   <= 1'b0;
                        r_o_sel   <= 1'b0;
                        r_o_last  <= 1'b0;
                        r_state   <= ST_NUM;
                    end
                end
                ST_NUM: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= 1'b1;
                        r_o_data  <= r_line[8:1];
                        r_o_pix   <= 1'b0;
                        r_o_sel   <= 1'b0;
                        r_o_last  <= 1'b0;
                        r_state   <= ST_ROW_RD;
                    end
                end
                ST_ROW_RD: begin
                    r_state <= ST_ROW_WT;
                end
                ST_ROW_WT: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= 1'b1;
                        r_o_data  <= mem_rdata;
                        r_o_pix   <= 1'b0;
                        r_o_sel   <= 1'b0;
                        r_o_last  <= 1'b0;
                        r_addr    <= r_addr + 1'b1;
                        r_cnt     <= r_cnt - 1'b1;
                        r_state   <= (r_cnt == '0) ? ST_TAIL : ST_ROW_RD;
                    end
                end
                ST_TAIL: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= 1'b1;
                        r_o_data  <= mlfc_pkg::BYTE_ZERO;
                        r_o_pix   <= 1'b0;
                        r_o_sel   <= 1'b0;
                        r_o_last  <= 1'b1;
                        r_state   <= ST_IDLE;
                    end
                end
                ST_CMD0: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= 1'b1;
                        r_o_data  <= (r_mode == mlfc_pkg::MODE_CLR_DISP)
                                     ? (vcom_bits | cfg.clear_cmd_mask)
                                     : mlfc_pkg::BYTE_ZERO;
                        r_o_pix   <= 1'b0;
                        r_o_sel   <= 1'b0;
                        r_o_last  <= 1'b0;
                        r_state   <= ST_CMD1;
                    end
                end
                ST_CMD1: begin
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_kind  <= 1'b1;
                        r_o_data  <= mlfc_pkg::BYTE_ZERO;
                        r_o_pix   <= 1'b0;
                        r_o_sel   <= 1'b1;
                        r_o_last  <= 1'b1;
                        r_vcom    <= !r_vcom;
                        r_state   <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// Memory LCD frame controller testbench
// Drives host commands into the item stream and checks every result item
// against an in-bench model of the frame store, VCOM level and registers.
// A short directed run covers the edge cases. Random phases follow, each
// with its own rotation and command masks, and both stream sides idle at
// random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int PANEL_W       = mlfc_pkg::PANEL_WIDTH_DEF;
    localparam int PANEL_H       = mlfc_pkg::PANEL_HEIGHT_DEF;
    localparam int ROW_STRIDE    = mlfc_pkg::ROW_STRIDE_DEF;
    localparam int BYTES_PER_ROW = ROW_STRIDE / 8;
    localparam int STORE_BYTES   = ROW_STRIDE * PANEL_H / 8;
    localparam int CLEAR_CYCLES  = STORE_BYTES;
    localparam int unsigned RUN_LIMIT = 15_000_000;

    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       pixel_value;
        logic       select_end;
        logic       last;
    } t_lcd_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    logic [7:0]  pixel_store [STORE_BYTES];
    logic        vcom_level;
    logic [1:0]  cfg_rotation;
    logic [7:0]  cfg_write_cmd;
    logic [7:0]  cfg_vcom;
    logic [7:0]  cfg_clear_cmd;
    int          last_drawn_row;

    t_lcd_result expected_results [$];
    logic [21:0] recent_points [$];
    int          error_count;
    int unsigned cycle_count;
    int          sink_wait;
    bit          gap_enable;
    bit          stall_enable;

    memory_lcd_frame_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic void fill_store();
        for (int i = 0; i < STORE_BYTES; i++) begin
            pixel_store[i] = mlfc_pkg::BYTE_FILL;
        end
    endfunction

    function automatic logic locate_pixel(input int x, input int y,
                                          output int byte_ix, output int bit_ix);
        int w, h, px, py, lin;
        byte_ix = 0;
        bit_ix  = 0;
        w = cfg_rotation[0] ? PANEL_H : PANEL_W;
        h = cfg_rotation[0] ? PANEL_W : PANEL_H;
        if (x < 0 || x >= w || y < 0 || y >= h) begin
            return 1'b0;
        end
        case (cfg_rotation)
            mlfc_pkg::ROT_90: begin
                px = PANEL_W - 1 - y;
                py = x;
            end
            mlfc_pkg::ROT_180: begin
                px = PANEL_W - 1 - x;
                py = PANEL_H - 1 - y;
            end
            mlfc_pkg::ROT_270: begin
                px = y;
                py = PANEL_H - 1 - x;
            end
            default: begin
                px = x;
                py = y;
            end
        endcase
        lin = (py * ROW_STRIDE + px) / 8;
        if (lin >= STORE_BYTES) begin
            return 1'b0;
        end
        byte_ix = lin;
        bit_ix  = px % 8;
        return 1'b1;
    endfunction

    function automatic void push_result(input logic kind, input logic [7:0] data_byte,
                                        input logic pixel_value, input logic select_end,
                                        input logic last);
        t_lcd_result r;
        r.kind        = kind;
        r.data_byte   = data_byte;
        r.pixel_value = pixel_value;
        r.select_end  = select_end;
        r.last        = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_command(input logic [2:0] mode, input logic [10:0] x_pos,
                                            input logic [10:0] y_pos, input logic color);
        int         xi, yi, byte_ix, bit_ix, line;
        logic [7:0] vcom_bits, hdr;
        logic       pix;
        xi = $signed(x_pos);
        yi = $signed(y_pos);
        vcom_bits = vcom_level ? cfg_vcom : mlfc_pkg::BYTE_ZERO;
        case (mode)
            mlfc_pkg::MODE_DRAW: begin
                if (locate_pixel(xi, yi, byte_ix, bit_ix)) begin
                    pixel_store[byte_ix][bit_ix] = color;
                    last_drawn_row = byte_ix / BYTES_PER_ROW;
                end
            end
            mlfc_pkg::MODE_READ: begin
                pix = 1'b0;
                if (locate_pixel(xi, yi, byte_ix, bit_ix)) begin
                    pix = pixel_store[byte_ix][bit_ix];
                end
                push_result(1'b0, mlfc_pkg::BYTE_ZERO, pix, 1'b0, 1'b1);
            end
            mlfc_pkg::MODE_CLR_STORE: begin
                fill_store();
            end
            mlfc_pkg::MODE_CLR_DISP: begin
                fill_store();
                push_result(1'b1, vcom_bits | cfg_clear_cmd, 1'b0, 1'b0, 1'b0);
                push_result(1'b1, mlfc_pkg::BYTE_ZERO, 1'b0, 1'b1, 1'b1);
                vcom_level = ~vcom_level;
            end
            mlfc_pkg::MODE_REFRESH: begin
                if (yi >= 0 && yi < PANEL_H) begin
                    line = yi + 1;
                    hdr = ((line % 2 == 1) ? mlfc_pkg::LINE_ODD_BIT : mlfc_pkg::BYTE_ZERO)
                          | vcom_bits | cfg_write_cmd;
                    push_result(1'b1, hdr, 1'b0, 1'b0, 1'b0);
                    push_result(1'b1, 8'((line >> 1) & 8'hFF), 1'b0, 1'b0, 1'b0);
                    for (int i = 0; i < BYTES_PER_ROW; i++) begin
                        if (yi * BYTES_PER_ROW + i < STORE_BYTES) begin
                            push_result(1'b1, pixel_store[yi * BYTES_PER_ROW + i],
                                        1'b0, 1'b0, 1'b0);
                        end else begin
                            push_result(1'b1, mlfc_pkg::BYTE_FILL, 1'b0, 1'b0, 1'b0);
                        end
                    end
                    push_result(1'b1, mlfc_pkg::BYTE_ZERO, 1'b0, 1'b0, 1'b1);
                end
            end
            mlfc_pkg::MODE_END_FRAME: begin
                push_result(1'b1, mlfc_pkg::BYTE_ZERO, 1'b0, 1'b0, 1'b0);
                push_result(1'b1, mlfc_pkg::BYTE_ZERO, 1'b0, 1'b1, 1'b1);
                vcom_level = ~vcom_level;
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge i_clk) begin : result_sink
        t_lcd_result want, got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.kind        = m_axis_tuser;
            got.data_byte   = m_axis_tdata[7:0];
            got.pixel_value = m_axis_tdata[8];
            got.select_end  = m_axis_tdata[9];
            got.last        = m_axis_tlast;
            if (expected_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result kind=%0d data=%02h", $time,
                         got.kind, got.data_byte,
                         " pixel=%0d sel_end=%0d last=%0d",
                         got.pixel_value, got.select_end, got.last);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t: mismatch expected kind=%0d data=%02h", $time,
                             want.kind, want.data_byte,
                             " pixel=%0d sel_end=%0d last=%0d",
                             want.pixel_value, want.select_end, want.last);
                    $display("%0t:          actual   kind=%0d data=%02h", $time,
                             got.kind, got.data_byte,
                             " pixel=%0d sel_end=%0d last=%0d",
                             got.pixel_value, got.select_end, got.last);
                end
            end
            sink_wait = stall_enable ? $urandom_range(0, 19) : 0;
            if (sink_wait != 0) begin
                m_axis_tready <= 1'b0;
            end
        end else if (!m_axis_tready) begin
            if (sink_wait != 0) begin
                sink_wait--;
            end
            if (sink_wait == 0) begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_command(input logic [2:0] mode, input logic [10:0] x_pos,
                                input logic [10:0] y_pos, input logic color);
        int gap;
        gap = gap_enable ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, color, y_pos, x_pos};
        s_axis_tuser  <= mode;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_command(mode, x_pos, y_pos, color);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // A clear or draw leaves no result behind, so allow a full store walk.
    task automatic settle_idle();
        wait_for_drain();
        repeat (CLEAR_CYCLES + 64) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            mlfc_pkg::REG_ROTATION:  cfg_rotation  = value[1:0];
            mlfc_pkg::REG_WRITE_CMD: cfg_write_cmd = value[7:0];
            mlfc_pkg::REG_VCOM:      cfg_vcom      = value[7:0];
            mlfc_pkg::REG_CLEAR_CMD: cfg_clear_cmd = value[7:0];
            default: begin
            end
        endcase
    endtask

    task automatic test_directed_defaults();
        gap_enable   = 1'b1;
        stall_enable = 1'b1;
        send_command(mlfc_pkg::MODE_REFRESH, 11'd0, 11'd0, 1'b0);
        send_command(mlfc_pkg::MODE_DRAW, 11'd0, 11'd0, 1'b0);
        send_command(mlfc_pkg::MODE_DRAW, 11'd229, 11'd302, 1'b0);
        send_command(mlfc_pkg::MODE_DRAW, 11'h7FF, 11'd5, 1'b0);
        send_command(mlfc_pkg::MODE_DRAW, 11'd230, 11'd5, 1'b0);
        send_command(mlfc_pkg::MODE_DRAW, 11'd5, 11'd303, 1'b0);
        send_command(mlfc_pkg::MODE_DRAW, 11'h400, 11'h3FF, 1'b0);
        send_command(mlfc_pkg::MODE_READ, 11'd0, 11'd0, 1'b0);
        send_command(mlfc_pkg::MODE_READ, 11'd229, 11'd302, 1'b1);
        send_command(mlfc_pkg::MODE_READ, 11'd1, 11'd0, 1'b0);
        send_command(mlfc_pkg::MODE_READ, 11'h400, 11'h400, 1'b1);
        send_command(mlfc_pkg::MODE_READ, 11'h3FF, 11'h3FF, 1'b0);
        send_command(mlfc_pkg::MODE_REFRESH, 11'h7FF, 11'd302, 1'b1);
        send_command(mlfc_pkg::MODE_REFRESH, 11'd0, 11'h7FF, 1'b0);
        send_command(mlfc_pkg::MODE_REFRESH, 11'd0, 11'd303, 1'b0);
        send_command(mlfc_pkg::MODE_REFRESH, 11'h3FF, 11'h3FF, 1'b1);
        send_command(mlfc_pkg::MODE_REFRESH, 11'h400, 11'h400, 1'b0);
        send_command(MODE_UNUSED_6, 11'($urandom), 11'($urandom), 1'b1);
        send_command(MODE_UNUSED_7, 11'($urandom), 11'($urandom), 1'b0);
        send_command(mlfc_pkg::MODE_END_FRAME, 11'd0, 11'd0, 1'b0);
        send_command(mlfc_pkg::MODE_REFRESH, 11'd0, 11'd1, 1'b0);
        wait_for_drain();
        send_command(mlfc_pkg::MODE_DRAW, 11'd0, 11'd0, 1'b1);
        send_command(mlfc_pkg::MODE_READ, 11'd0, 11'd0, 1'b0);
        send_command(mlfc_pkg::MODE_CLR_DISP, 11'd0, 11'd0, 1'b0);
        send_command(mlfc_pkg::MODE_READ, 11'd229, 11'd302, 1'b0);
        send_command(mlfc_pkg::MODE_CLR_STORE, 11'd0, 11'd0, 1'b0);
        settle_idle();
    endtask

    task automatic test_random_commands(input int count, input logic [1:0] rotation,
                                        input logic [7:0] write_cmd, input logic [7:0] vcom,
                                        input logic [7:0] clear_cmd);
        int          sent, pick, w, h, r;
        logic [2:0]  mode;
        logic [10:0] xr, yr;
        logic        color;
        write_register(mlfc_pkg::REG_ROTATION, {30'd0, rotation});
        write_register(mlfc_pkg::REG_WRITE_CMD, {24'd0, write_cmd});
        write_register(mlfc_pkg::REG_VCOM, {24'd0, vcom});
        write_register(mlfc_pkg::REG_CLEAR_CMD, {24'd0, clear_cmd});
        recent_points.delete();
        w = cfg_rotation[0] ? PANEL_H : PANEL_W;
        h = cfg_rotation[0] ? PANEL_W : PANEL_H;
        sent = 0;
        while (sent < count) begin
            if (sent % 20 == 0) begin
                gap_enable   = ($urandom_range(0, 3) != 0);
                stall_enable = ($urandom_range(0, 3) != 0);
            end
            pick  = $urandom_range(0, 99);
            xr    = 11'($urandom_range(0, 2047));
            yr    = 11'($urandom_range(0, 2047));
            color = 1'($urandom_range(0, 1));
            if (pick < 40) begin
                mode = mlfc_pkg::MODE_DRAW;
                if ($urandom_range(0, 9) != 0) begin
                    xr = 11'($urandom_range(0, w - 1));
                    yr = 11'($urandom_range(0, h - 1));
                end
                recent_points.push_back({yr, xr});
                if (recent_points.size() > 16) begin
                    void'(recent_points.pop_front());
                end
            end else if (pick < 65) begin
                mode = mlfc_pkg::MODE_READ;
                if (recent_points.size() != 0 && $urandom_range(0, 1) == 1) begin
                    {yr, xr} = recent_points[$urandom_range(0, recent_points.size() - 1)];
                end else if ($urandom_range(0, 9) != 0) begin
                    xr = 11'($urandom_range(0, w - 1));
                    yr = 11'($urandom_range(0, h - 1));
                end
            end else if (pick < 85) begin
                mode = mlfc_pkg::MODE_REFRESH;
                r = $urandom_range(0, 9);
                if (r < 4) begin
                    yr = 11'(last_drawn_row);
                end else if (r < 9) begin
                    yr = 11'($urandom_range(0, PANEL_H - 1));
                end
            end else if (pick < 92) begin
                mode = mlfc_pkg::MODE_END_FRAME;
            end else if (pick < 96) begin
                mode = ($urandom_range(0, 1) == 1) ? MODE_UNUSED_6 : MODE_UNUSED_7;
            end else if (pick < 98) begin
                mode = mlfc_pkg::MODE_CLR_STORE;
            end else begin
                mode = mlfc_pkg::MODE_CLR_DISP;
            end
            send_command(mode, xr, yr, color);
            if (mode != MODE_UNUSED_6 && mode != MODE_UNUSED_7) begin
                sent++;
            end
        end
        settle_idle();
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= mlfc_pkg::MODE_DRAW;
        m_axis_tready <= 1'b1;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        cycle_count   = 0;
        error_count   = 0;
        sink_wait     = 0;
        gap_enable    = 1'b0;
        stall_enable  = 1'b0;
        vcom_level    = 1'b1;
        cfg_rotation  = mlfc_pkg::ROTATION_RST;
        cfg_write_cmd = mlfc_pkg::WRITE_CMD_RST;
        cfg_vcom      = mlfc_pkg::VCOM_RST;
        cfg_clear_cmd = mlfc_pkg::CLEAR_CMD_RST;
        last_drawn_row = 0;
        fill_store();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_defaults();
        test_random_commands(60, mlfc_pkg::ROT_0, 8'h00, 8'h00, 8'h00);
        test_random_commands(60, mlfc_pkg::ROT_90, 8'hFF, 8'hFF, 8'hFF);
        test_random_commands(60, mlfc_pkg::ROT_180, 8'($urandom), 8'($urandom),
                             8'($urandom));
        test_random_commands(60, mlfc_pkg::ROT_270, 8'($urandom), 8'($urandom),
                             8'($urandom));
        test_random_commands(60, 2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));

        wait_for_drain();
        repeat (200) @(posedge i_clk);
        if (error_count == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

### files.f
sv/mlfc_pkg.sv
sv/mlfc_regs.sv
sv/mlfc_store.sv
sv/mlfc_locate.sv
sv/memory_lcd_frame_controller.sv
tb/tb.sv
